[hw/rtl/dictionary_word_compressor_defines.svh]
// assertion macros shared by the dictionary word compressor rtl
`ifndef DICTIONARY_WORD_COMPRESSOR_DEFINES_SVH
`define DICTIONARY_WORD_COMPRESSOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, switched off while reset is asserted
`define DWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property that also holds while reset is asserted
`define DWC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DWC_ASSERT(label, prop, msg)
`define DWC_ASSERT_RST(label, prop, msg)
`endif

`endif

[hw/rtl/dwc_pkg.sv]
// types and constants of the dictionary word compressor
package dwc_pkg;

    // slots reachable through the entry_index field
    localparam int INDEX_W    = 3;
    localparam int INDEX_SPAN = 1 << INDEX_W;

    typedef logic [INDEX_W-1:0] index_field_t;
    typedef logic [31:0]        word_field_t;
    typedef logic [4:0]         pos_field_t;

    typedef enum logic
    {
        CMD_LOAD     = 1'b0,
        CMD_COMPRESS = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        KIND_NONE   = 2'd0,
        KIND_DIRECT = 2'd1,
        KIND_SINGLE = 2'd2
    } match_kind_t;

endpackage

[hw/rtl/dwc_item_if.sv]
// input channel: load or compress transactions
interface dwc_item_if;
    logic                  valid;
    logic                  ready;
    dwc_pkg::command_t     command;
    dwc_pkg::index_field_t entry_index;
    dwc_pkg::word_field_t  word;

    modport source (output valid, output command, output entry_index, output word, input ready);
    modport sink   (input valid, input command, input entry_index, input word, output ready);
endinterface

[hw/rtl/dwc_result_if.sv]
// output channel: classification result transactions
interface dwc_result_if;
    logic                  valid;
    logic                  ready;
    dwc_pkg::match_kind_t  match_kind;
    dwc_pkg::index_field_t dict_index;
    dwc_pkg::pos_field_t   mismatch_pos;

    modport source (output valid, output match_kind, output dict_index, output mismatch_pos,
                    input ready);
    modport sink   (input valid, input match_kind, input dict_index, input mismatch_pos,
                    output ready);
endinterface

[hw/rtl/dictionary_word_compressor.sv]
// top level of the dictionary word compressor
//
//  channel   dir  transaction                            fields
//  items     in   load a slot or compress one word       command, entry_index, word
//  results   out  one per compress, none per load        match_kind, dict_index, mismatch_pos
//
// one transaction per cycle on items while results is not stalled, through four register stages
// a compress result goes from the input register through the compare, select and result registers
// loads write the slot from the input stage and leave the pipe there
// reset clears the slot valid bits and all stage valids at once; no sweep
// a stall on results backs up the stages; loads in stage 1 still retire; nothing is dropped or repeated
module dictionary_word_compressor #(
    parameter int DICT_ENTRIES = 8,
    parameter int WORD_BITS    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    dwc_item_if.sink            items,
    dwc_result_if.source        results
);
    import dwc_pkg::*;

    // entry_index reaches only the first slots, so storage stops there
    localparam int SLOTS = (DICT_ENTRIES < INDEX_SPAN) ? DICT_ENTRIES : INDEX_SPAN;

    // stage 2: per-slot compare flags and difference words
    logic                            cmp_valid;
    logic                            cmp_ready;
    logic [SLOTS-1:0]                eq_vec;
    logic [SLOTS-1:0]                one_vec;
    logic [SLOTS-1:0][WORD_BITS-1:0] diff_vec;

    // stage 3: chosen slot, kind and its difference word
    logic                            sel_valid;
    logic                            sel_ready;
    match_kind_t                     sel_kind;
    index_field_t                    sel_slot;
    logic [WORD_BITS-1:0]            sel_diff;

    // stage 1 and 2: input register, slot storage and compare
    dwc_dict #(
        .SLOTS     (SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_dict (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (items.valid),
        .in_ready    (items.ready),
        .command     (items.command),
        .entry_index (items.entry_index),
        .word        (items.word),
        .cmp_valid   (cmp_valid),
        .cmp_ready   (cmp_ready),
        .eq_vec      (eq_vec),
        .one_vec     (one_vec),
        .diff_vec    (diff_vec)
    );

    // stage 3: lowest-slot priority pick
    dwc_select #(
        .SLOTS     (SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmp_valid (cmp_valid),
        .cmp_ready (cmp_ready),
        .eq_vec    (eq_vec),
        .one_vec   (one_vec),
        .diff_vec  (diff_vec),
        .sel_valid (sel_valid),
        .sel_ready (sel_ready),
        .sel_kind  (sel_kind),
        .sel_slot  (sel_slot),
        .sel_diff  (sel_diff)
    );

    // stage 4: bit position encode into the result register
    dwc_encode #(
        .WORD_BITS (WORD_BITS)
    ) u_encode (
        .clk          (clk),
        .rst_n        (rst_n),
        .sel_valid    (sel_valid),
        .sel_ready    (sel_ready),
        .sel_kind     (sel_kind),
        .sel_slot     (sel_slot),
        .sel_diff     (sel_diff),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .match_kind   (results.match_kind),
        .dict_index   (results.dict_index),
        .mismatch_pos (results.mismatch_pos)
    );
endmodule

[hw/rtl/dwc_dict.sv]
// input stage, dictionary storage and per-slot compare stage
module dwc_dict #(
    parameter int SLOTS     = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dwc_pkg::command_t               command,
    input  dwc_pkg::index_field_t           entry_index,
    input  dwc_pkg::word_field_t            word,
    output logic                            cmp_valid,
    input  logic                            cmp_ready,
    output logic [SLOTS-1:0]                eq_vec,
    output logic [SLOTS-1:0]                one_vec,
    output logic [SLOTS-1:0][WORD_BITS-1:0] diff_vec
);
    import dwc_pkg::*;
    `include "dictionary_word_compressor_defines.svh"

    logic                            s1_valid_reg, s1_valid_next;
    command_t                        s1_cmd_reg, s1_cmd_next;
    index_field_t                    s1_idx_reg, s1_idx_next;
    logic [WORD_BITS-1:0]            s1_word_reg, s1_word_next;
    logic [SLOTS-1:0][WORD_BITS-1:0] dict_reg, dict_next;
    logic [SLOTS-1:0]                entry_valid_reg, entry_valid_next;
    logic                            s2_valid_reg, s2_valid_next;
    logic [SLOTS-1:0]                eq_reg, eq_next;
    logic [SLOTS-1:0]                one_reg, one_next;
    logic [SLOTS-1:0][WORD_BITS-1:0] diff_reg, diff_next;
    logic                            s2_free;
    logic                            s1_go;
    logic [SLOTS-1:0]                load_hit;

    // loads retire in stage 1, compresses move on to stage 2
    assign s2_free  = !s2_valid_reg || cmp_ready;
    assign s1_go    = s1_valid_reg && ((s1_cmd_reg == CMD_LOAD) || s2_free);
    assign in_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_cmd_next   = s1_cmd_reg;
        s1_idx_next   = s1_idx_reg;
        s1_word_next  = s1_word_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
            s1_cmd_next   = command;
            s1_idx_next   = entry_index;
            s1_word_next  = WORD_BITS'(word);
        end
    end

    // slot write and compare against the word held in stage 1
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            load_hit[i] = s1_valid_reg && (s1_cmd_reg == CMD_LOAD)
                          && (s1_idx_reg == index_field_t'(i));
            dict_next[i]        = load_hit[i] ? s1_word_reg : dict_reg[i];
            entry_valid_next[i] = entry_valid_reg[i] || load_hit[i];
            diff_next[i]        = dict_reg[i] ^ s1_word_reg;
            eq_next[i]          = entry_valid_reg[i] && (diff_next[i] == '0);
            one_next[i]         = entry_valid_reg[i] && (diff_next[i] != '0)
                                  && ((diff_next[i] & (diff_next[i] - WORD_BITS'(1))) == '0);
        end
    end

    assign s2_valid_next = s2_free ? (s1_valid_reg && (s1_cmd_reg == CMD_COMPRESS))
                                   : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= s1_cmd_next;
        s1_idx_reg  <= s1_idx_next;
        s1_word_reg <= s1_word_next;
        dict_reg    <= dict_next;
        if (s2_free)
        begin
            eq_reg   <= eq_next;
            one_reg  <= one_next;
            diff_reg <= diff_next;
        end
    end

    assign cmp_valid = s2_valid_reg;
    assign eq_vec    = eq_reg;
    assign one_vec   = one_reg;
    assign diff_vec  = diff_reg;

    `DWC_ASSERT(a_load_marks_valid, (|load_hit) |=> ((entry_valid_reg & $past(load_hit)) == $past(load_hit)), "loaded slot not marked valid")
endmodule

[hw/rtl/dwc_select.sv]
// priority select stage: lowest direct match, else lowest single-bit mismatch
module dwc_select #(
    parameter int SLOTS     = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmp_valid,
    output logic                            cmp_ready,
    input  logic [SLOTS-1:0]                eq_vec,
    input  logic [SLOTS-1:0]                one_vec,
    input  logic [SLOTS-1:0][WORD_BITS-1:0] diff_vec,
    output logic                            sel_valid,
    input  logic                            sel_ready,
    output dwc_pkg::match_kind_t            sel_kind,
    output dwc_pkg::index_field_t           sel_slot,
    output logic [WORD_BITS-1:0]            sel_diff
);
    import dwc_pkg::*;
    `include "dictionary_word_compressor_defines.svh"

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                 sel_valid_reg, sel_valid_next;
    match_kind_t          kind_reg, kind_next;
    index_field_t         slot_reg, slot_next;
    logic [WORD_BITS-1:0] diff_reg, diff_next;
    logic [SLOT_W-1:0]    eq_idx;
    logic [SLOT_W-1:0]    one_idx;

    assign cmp_ready = !sel_valid_reg || sel_ready;

    // scan from the top so the lowest set slot wins
    always_comb
    begin
        eq_idx  = '0;
        one_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (eq_vec[i])
            begin
                eq_idx = SLOT_W'(i);
            end
            if (one_vec[i])
            begin
                one_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        kind_next = KIND_NONE;
        slot_next = '0;
        diff_next = '0;
        priority if (|eq_vec)
        begin
            kind_next = KIND_DIRECT;
            slot_next = index_field_t'(eq_idx);
        end
        else if (|one_vec)
        begin
            kind_next = KIND_SINGLE;
            slot_next = index_field_t'(one_idx);
            diff_next = diff_vec[one_idx];
        end
        else
        begin
            kind_next = KIND_NONE;
        end
    end

    assign sel_valid_next = cmp_ready ? cmp_valid : sel_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
        end
        else
        begin
            sel_valid_reg <= sel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_ready)
        begin
            kind_reg <= kind_next;
            slot_reg <= slot_next;
            diff_reg <= diff_next;
        end
    end

    assign sel_valid = sel_valid_reg;
    assign sel_kind  = kind_reg;
    assign sel_slot  = slot_reg;
    assign sel_diff  = diff_reg;

    `DWC_ASSERT(a_direct_wins, (cmp_valid && cmp_ready && (|eq_vec)) |=> (kind_reg == KIND_DIRECT), "exact match not reported as direct")
endmodule

[hw/rtl/dwc_encode.sv]
// bit position encode stage and result register
module dwc_encode #(
    parameter int WORD_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sel_valid,
    output logic                  sel_ready,
    input  dwc_pkg::match_kind_t  sel_kind,
    input  dwc_pkg::index_field_t sel_slot,
    input  logic [WORD_BITS-1:0]  sel_diff,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dwc_pkg::match_kind_t  match_kind,
    output dwc_pkg::index_field_t dict_index,
    output dwc_pkg::pos_field_t   mismatch_pos
);
    import dwc_pkg::*;
    `include "dictionary_word_compressor_defines.svh"

    localparam int POS_W = $clog2(WORD_BITS);

    logic             out_valid_reg, out_valid_next;
    match_kind_t      kind_reg;
    index_field_t     index_reg;
    pos_field_t       pos_reg;
    logic [POS_W-1:0] pos_msb;

    assign sel_ready = !out_valid_reg || out_ready;

    // one-hot difference to position counted from the msb; zero difference gives zero
    always_comb
    begin
        pos_msb = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (sel_diff[b])
            begin
                pos_msb = pos_msb | POS_W'(WORD_BITS - 1 - b);
            end
        end
    end

    assign out_valid_next = sel_ready ? sel_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_ready)
        begin
            kind_reg  <= sel_kind;
            index_reg <= sel_slot;
            pos_reg   <= pos_field_t'(pos_msb);
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_kind   = kind_reg;
    assign dict_index   = index_reg;
    assign mismatch_pos = pos_reg;

    `DWC_ASSERT(a_single_is_onehot, (sel_valid && (sel_kind == KIND_SINGLE)) |-> $onehot(sel_diff), "single mismatch without exactly one differing bit")
    `DWC_ASSERT(a_uncompressed_zero, (out_valid_reg && (kind_reg == KIND_NONE)) |-> ((index_reg == '0) && (pos_reg == '0)), "uncompressed result with nonzero fields")
    `DWC_ASSERT_RST(a_reset_empties_output, !rst_n |=> !out_valid_reg, "result valid during reset")
endmodule

[test/dictionary_word_compressor_tb.sv]
// self-checking testbench for the dictionary word compressor
`timescale 1ns / 1ps

module dictionary_word_compressor_tb;

    import dwc_pkg::*;

    localparam int DICT_ENTRIES  = 8;
    localparam int WORD_BITS     = 32;
    localparam int RANDOM_ITEMS  = 1326;
    localparam int DRAIN_CYCLES  = 12;     // pipe is four stages deep
    localparam int STALL_LIMIT   = 2000;   // cycles with no transaction on either channel
    localparam int REPORT_LIMIT  = 10;

    // one classification as the block should report it
    typedef struct packed
    {
        match_kind_t  kind;
        index_field_t slot;
        pos_field_t   pos;
    } verdict_t;

    // mirror of the dictionary plus the queue of classifications still owed
    class dictionary_mirror;
        logic [WORD_BITS-1:0] slot_word [DICT_ENTRIES];
        bit                   slot_live [DICT_ENTRIES];
        verdict_t             expected_verdicts [$];
        int                   mismatches;

        function new();
            foreach (slot_live[i])
            begin
                slot_live[i] = 1'b0;
            end
            mismatches = 0;
        endfunction

        // exact hit wins over a one-bit hit; lowest slot wins within each
        function verdict_t classify_word(logic [WORD_BITS-1:0] w);
            verdict_t             v;
            logic [WORD_BITS-1:0] diff;
            bit                   found;
            v.kind = KIND_NONE;
            v.slot = '0;
            v.pos  = '0;
            found  = 1'b0;
            for (int i = 0; i < DICT_ENTRIES; i++)
            begin
                if (!found && slot_live[i] && slot_word[i] == w)
                begin
                    v.kind = KIND_DIRECT;
                    v.slot = index_field_t'(i);
                    found  = 1'b1;
                end
            end
            for (int i = 0; i < DICT_ENTRIES; i++)
            begin
                diff = slot_word[i] ^ w;
                if (!found && slot_live[i] && diff != '0 && (diff & (diff - 1'b1)) == '0)
                begin
                    v.kind = KIND_SINGLE;
                    v.slot = index_field_t'(i);
                    found  = 1'b1;
                    for (int b = 0; b < WORD_BITS; b++)
                    begin
                        if (diff[b])
                        begin
                            v.pos = pos_field_t'(WORD_BITS - 1 - b);
                        end
                    end
                end
            end
            return v;
        endfunction

        function void take_item(command_t cmd, index_field_t idx, word_field_t w);
            logic [WORD_BITS-1:0] masked;
            masked = w[WORD_BITS-1:0];
            if (cmd == CMD_LOAD)
            begin
                if (int'(idx) < DICT_ENTRIES)
                begin
                    slot_word[idx] = masked;
                    slot_live[idx] = 1'b1;
                end
            end
            else
            begin
                expected_verdicts.insert(expected_verdicts.size(), classify_word(masked));
            end
        endfunction

        function void check_verdict(match_kind_t kind, index_field_t slot, pos_field_t pos);
            verdict_t want;
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: result with nothing pending: kind %0d slot %0d pos %0d",
                             $realtime, kind, slot, pos);
                end
                return;
            end
            want = expected_verdicts.pop_front();
            if (want.kind != kind || want.slot != slot || want.pos != pos)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: result mismatch: expected kind %0d slot %0d pos %0d, got kind %0d slot %0d pos %0d",
                             $realtime, want.kind, want.slot, want.pos, kind, slot, pos);
                end
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dwc_item_if   item_bus ();
    dwc_result_if result_bus ();

    dictionary_word_compressor #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .WORD_BITS    (WORD_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_bus.sink),
        .results (result_bus.source)
    );

    dictionary_mirror mirror;

    // idle pattern state per side: 0 is the item sender, 1 the result receiver
    int burst_left  [2] = '{0, 0};
    bit burst_quiet [2] = '{0, 0};
    int idle_cycles = 0;

    always #2 clk = ~clk;

    // waits are drawn per transaction; every so often a stretch of back-to-back
    // transactions is forced so the full-rate path gets exercised too
    function int draw_wait(int side);
        if (burst_left[side] == 0)
        begin
            burst_left[side]  = $urandom_range(4, 40);
            burst_quiet[side] = ($urandom_range(0, 2) == 0);
        end
        burst_left[side]--;
        return burst_quiet[side] ? 0 : int'($urandom_range(0, 14));
    endfunction

    // one transaction on the item channel; valid stays high into the next
    // call when no gap is drawn, so it is never dropped and raised in one step
    task send_item(command_t cmd, index_field_t idx, word_field_t w);
        int gap;
        gap = draw_wait(0);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.command     <= cmd;
        item_bus.entry_index <= idx;
        item_bus.word        <= w;
        @(posedge clk);
        while (!item_bus.ready)
        begin
            @(posedge clk);
        end
        mirror.take_item(cmd, idx, w);
    endtask

    // corner cases: empty dictionary, all-zero and all-one slots, mismatch on
    // the first and the last bit, rewrite of a live slot, duplicate slots,
    // exact hit beating a one-bit hit in a lower slot, two-bit distance
    task run_directed();
        send_item(CMD_COMPRESS, 3'd5, 32'hA5A5A5A5);   // nothing live yet
        send_item(CMD_LOAD,     3'd0, 32'h00000000);
        send_item(CMD_LOAD,     3'd7, 32'hFFFFFFFF);
        send_item(CMD_COMPRESS, 3'd0, 32'h00000000);
        send_item(CMD_COMPRESS, 3'd7, 32'hFFFFFFFF);
        send_item(CMD_COMPRESS, 3'd0, 32'h80000000);   // msb off by one
        send_item(CMD_COMPRESS, 3'd0, 32'h00000001);   // lsb off by one
        send_item(CMD_COMPRESS, 3'd0, 32'hFFFFFFFE);
        send_item(CMD_COMPRESS, 3'd0, 32'h7FFFFFFF);
        send_item(CMD_COMPRESS, 3'd0, 32'h00000003);   // two bits away
        send_item(CMD_LOAD,     3'd0, 32'h12345678);   // rewrite slot 0
        send_item(CMD_COMPRESS, 3'd0, 32'h00000000);
        send_item(CMD_COMPRESS, 3'd0, 32'h12345678);
        send_item(CMD_LOAD,     3'd3, 32'h12345678);   // same data in a higher slot
        send_item(CMD_COMPRESS, 3'd0, 32'h12345678);
        send_item(CMD_LOAD,     3'd2, 32'h1234567C);
        send_item(CMD_COMPRESS, 3'd0, 32'h1234567C);   // exact in slot 2 beats slot 0
        send_item(CMD_COMPRESS, 3'd0, 32'h1234567D);
        send_item(CMD_COMPRESS, 3'd0, 32'h1234567A);
        send_item(CMD_LOAD,     3'd5, 32'h5A5A5A5A);
        send_item(CMD_LOAD,     3'd1, 32'hC3C3C3C3);
        send_item(CMD_LOAD,     3'd4, 32'h0F0F0F0F);
        send_item(CMD_LOAD,     3'd6, 32'hF0F0F0F0);
        send_item(CMD_COMPRESS, 3'd0, 32'h0F0F0F0E);
    endtask

    // mostly compresses of words close to live entries, so exact and
    // one-bit hits dominate; loads sometimes copy or nearly copy another
    // slot to keep priority between slots in play
    task run_random(int count);
        int           live [$];
        int           pick;
        int           flavor;
        int           b;
        word_field_t  w;
        index_field_t idx;
        for (int n = 0; n < count; n++)
        begin
            live.delete();
            foreach (mirror.slot_live[i])
            begin
                if (mirror.slot_live[i])
                begin
                    live.insert(live.size(), i);
                end
            end
            w      = $urandom();
            idx    = index_field_t'($urandom_range(0, INDEX_SPAN - 1));
            flavor = $urandom_range(0, 9);
            if (live.size() > 0)
            begin
                pick = live[$urandom_range(0, live.size() - 1)];
            end
            else
            begin
                pick = -1;
            end
            if ($urandom_range(0, 99) < 18)
            begin
                // load: random data, a copy of a slot, or a copy off by one bit
                if (pick >= 0 && flavor < 5)
                begin
                    w = mirror.slot_word[pick];
                    if (flavor < 3)
                    begin
                        b    = $urandom_range(0, WORD_BITS - 1);
                        w[b] = ~w[b];
                    end
                end
                send_item(CMD_LOAD, idx, w);
            end
            else
            begin
                // compress: exact copy, one flipped bit, two flipped bits, or noise
                if (pick >= 0 && flavor < 8)
                begin
                    w = mirror.slot_word[pick];
                    if (flavor >= 3)
                    begin
                        b    = $urandom_range(0, WORD_BITS - 1);
                        w[b] = ~w[b];
                    end
                    if (flavor == 7)
                    begin
                        b    = (b + $urandom_range(1, WORD_BITS - 1)) % WORD_BITS;
                        w[b] = ~w[b];
                    end
                end
                send_item(CMD_COMPRESS, idx, w);
            end
        end
    endtask

    // result receiver: random back-pressure per transaction, checks each
    // accepted result against the oldest pending classification
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(1);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge clk);
            while (!result_bus.valid)
            begin
                @(posedge clk);
            end
            mirror.check_verdict(result_bus.match_kind, result_bus.dict_index,
                                 result_bus.mismatch_pos);
        end
    end

    // watchdog: too long without any transaction means the block is stuck
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // main sequence: reset, directed corners, random traffic, drain, verdict
    initial
    begin
        mirror = new();
        item_bus.valid       <= 1'b0;
        item_bus.command     <= CMD_LOAD;
        item_bus.entry_index <= '0;
        item_bus.word        <= '0;
        result_bus.ready     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_ITEMS);
        item_bus.valid <= 1'b0;
        while (mirror.expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        // catch any stray result the block might still emit
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.expected_verdicts.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
